// ----- rtl/core/arqrr_pkg.sv -----
// Shared types for the ARQ reorder receiver.
// No dependencies; imported by every module of the block.
package arqrr_pkg;

    typedef struct packed {
        logic [15:0] seq_no;
        logic [5:0]  frame_len;
        logic [15:0] frame_sum;
        logic [7:0]  data_byte;
        logic        frame_last;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] ack_seq;
        logic [63:0] data_word;
        logic [3:0]  word_bytes;
        logic        run_last;
    } out_t;

    // One judged good frame waiting for the back end
    typedef struct packed {
        logic [15:0] seq_no;
        logic [5:0]  frame_len;
        logic        bank;
    } cmd_t;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;
    localparam logic [5:0] BYTE_COUNT_MAX = 6'd63;

endpackage

// ----- rtl/core/arqrr_front.sv -----
// Front end: accepts bytes, keeps checksum and count, writes the staging banks
// and judges each frame on its last item. Depends on arqrr_pkg.
module arqrr_front #(
    parameter int MAX_FRAME_BYTES = 46,
    parameter int SW = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  arqrr_pkg::in_t   s_data,
    input  logic             q_full,
    output logic             push,
    output arqrr_pkg::cmd_t  push_cmd,
    output logic             stg_we,
    output logic [SW-1:0]    stg_waddr,
    output logic [7:0]       stg_wdata
);
    import arqrr_pkg::*;

    localparam logic [5:0] MAXL = 6'(MAX_FRAME_BYTES);

    logic [15:0] sum_reg, sum_next, sum_new;
    logic [5:0]  cnt_reg, cnt_next, cnt_new;
    logic        ovr_reg, ovr_next, ovr_new;
    logic        bank_reg, bank_next;
    logic        acc, has, good;

    always_comb begin
        acc     = s_valid && s_ready;
        has     = s_data.frame_len != 6'd0;
        sum_new = has ? sum_reg + 16'(s_data.data_byte) : sum_reg;
        cnt_new = (has && cnt_reg != BYTE_COUNT_MAX) ? cnt_reg + 6'd1 : cnt_reg;
        ovr_new = ovr_reg || (has && cnt_reg == BYTE_COUNT_MAX);
        good    = s_data.frame_len <= MAXL && cnt_new == s_data.frame_len && !ovr_new
                  && sum_new == s_data.frame_sum;
        stg_we    = acc && has && cnt_reg < MAXL;
        stg_waddr = bank_reg ? SW'(MAX_FRAME_BYTES) + SW'(cnt_reg) : SW'(cnt_reg);
        stg_wdata = s_data.data_byte;
        push      = acc && s_data.frame_last && good;
        push_cmd.seq_no    = s_data.seq_no;
        push_cmd.frame_len = s_data.frame_len;
        push_cmd.bank      = bank_reg;

        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        ovr_next  = ovr_reg;
        bank_next = bank_reg;
        if (acc) begin
            if (s_data.frame_last) begin
                sum_next = 16'd0;
                cnt_next = 6'd0;
                ovr_next = 1'b0;
                // hand the filled bank over, fill the other one next
                if (push) begin
                    bank_next = !bank_reg;
                end
            end else begin
                sum_next = sum_new;
                cnt_next = cnt_new;
                ovr_next = ovr_new;
            end
        end
    end

    assign s_ready = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= 16'd0;
            cnt_reg  <= 6'd0;
            ovr_reg  <= 1'b0;
            bank_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            ovr_reg  <= ovr_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// ----- rtl/core/arqrr_cmdq.sv -----
// Two-entry queue of judged frames between front and back end.
// Depends on arqrr_pkg.
module arqrr_cmdq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  arqrr_pkg::cmd_t  push_cmd,
    input  logic             pop,
    output arqrr_pkg::cmd_t  head,
    output logic             full,
    output logic             empty
);
    import arqrr_pkg::*;

    cmd_t       ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/arqrr_back.sv -----
// Back end: acknowledges a frame, copies it from staging into its window slot when it
// is in the window, drains the in-order run as packed words. Holds both byte memories and the
// output register. Depends on arqrr_pkg.
module arqrr_back #(
    parameter int MAX_FRAME_BYTES = 46,
    parameter int WINDOW_FRAMES = 8,
    parameter int SW = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             stg_we,
    input  logic [SW-1:0]    stg_waddr,
    input  logic [7:0]       stg_wdata,
    input  logic             q_empty,
    input  arqrr_pkg::cmd_t  q_head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output arqrr_pkg::out_t  m_data
);
    import arqrr_pkg::*;

    localparam int SD = 2 * MAX_FRAME_BYTES;
    localparam int MD = WINDOW_FRAMES * MAX_FRAME_BYTES;
    localparam int AW = $clog2(MD);
    localparam int HW = $clog2(WINDOW_FRAMES);
    localparam logic [AW-1:0] MAXA = AW'(MAX_FRAME_BYTES);
    localparam logic [HW:0] WINW = (HW+1)'(WINDOW_FRAMES);
    localparam logic [HW-1:0] HLAST = HW'(WINDOW_FRAMES - 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ACK  = 3'd1;
    localparam logic [2:0] B_COPY = 3'd2;
    localparam logic [2:0] B_CHK  = 3'd3;
    localparam logic [2:0] B_RD   = 3'd4;
    localparam logic [2:0] B_EMIT = 3'd5;
    localparam logic [2:0] B_FIN  = 3'd6;

    logic [7:0] stg_mem [SD];
    logic [7:0] slot_mem [MD];
    logic [7:0] stg_q, slot_q;
    logic [SW-1:0] stg_raddr;
    logic [AW-1:0] slot_raddr;

    logic [2:0]  st_reg, st_next;
    cmd_t        cmd_reg, cmd_next;
    logic [15:0] exp_reg, exp_next;
    logic [HW-1:0] head_reg, head_next;
    logic [WINDOW_FRAMES-1:0] valid_reg, valid_next;
    logic [5:0]  slen_reg [WINDOW_FRAMES];
    logic        slen_we;
    logic [HW-1:0] slot_reg, slot_next;
    logic [AW-1:0] base_reg, base_next;
    logic [5:0]  cpi_reg, cpi_next;
    logic        cwv_reg, cwv_next;
    logic [AW-1:0] cwa_reg, cwa_next;
    logic [5:0]  flen_reg, flen_next;
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  wcnt_reg, wcnt_next;
    logic [3:0]  iss_reg, iss_next;
    logic        rv_reg, rv_next;
    logic [2:0]  lane_reg, lane_next;
    logic [63:0] word_reg, word_next;
    logic        pv_reg, pv_next;
    out_t        pend_reg, pend_next;
    logic        mv_reg, mv_next;
    out_t        md_reg, md_next;

    logic [15:0] off;
    logic        inwin, out_ok, emit_ok, emit, issue, retire;
    logic [HW:0] ssum;
    logic [HW-1:0] slot_c;
    logic [5:0]  pos_new;
    out_t        res;

    always_ff @(posedge aclk) begin
        if (stg_we) begin
            stg_mem[stg_waddr] <= stg_wdata;
        end
        stg_q <= stg_mem[stg_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cwv_reg) begin
            slot_mem[cwa_reg] <= stg_q;
        end
        slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (slen_we) begin
            slen_reg[slot_reg] <= cmd_reg.frame_len;
        end
    end

    always_comb begin
        off    = cmd_reg.seq_no - exp_reg;
        inwin  = off < 16'(WINDOW_FRAMES);
        ssum   = (HW+1)'(head_reg) + (HW+1)'(off[5:0]);
        slot_c = (ssum >= WINW) ? HW'(ssum - WINW) : HW'(ssum);
        out_ok  = !mv_reg || m_ready;
        emit_ok = !pv_reg || out_ok;
        pos_new = pos_reg + 6'(wcnt_reg);
        stg_raddr  = cmd_reg.bank ? SW'(MAX_FRAME_BYTES) + SW'(cpi_reg) : SW'(cpi_reg);
        slot_raddr = base_reg + AW'(pos_reg) + AW'(iss_reg);

        st_next = st_reg; cmd_next = cmd_reg; exp_next = exp_reg; head_next = head_reg;
        valid_next = valid_reg; slot_next = slot_reg; base_next = base_reg;
        cpi_next = cpi_reg; cwv_next = 1'b0; cwa_next = cwa_reg;
        flen_next = flen_reg; pos_next = pos_reg; wcnt_next = wcnt_reg; iss_next = iss_reg;
        rv_next = 1'b0; lane_next = lane_reg; word_next = word_reg;
        slen_we = 1'b0; pop = 1'b0; emit = 1'b0; issue = 1'b0; retire = 1'b0;
        res = '0;

        if (rv_reg) begin
            word_next[lane_reg*8 +: 8] = slot_q;
        end

        unique case (st_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    cmd_next = q_head;
                    st_next  = B_ACK;
                end
            end
            B_ACK: begin
                res.kind    = KIND_ACK;
                res.ack_seq = cmd_reg.seq_no;
                if (emit_ok) begin
                    emit      = 1'b1;
                    slot_next = slot_c;
                    base_next = AW'(slot_c) * MAXA;
                    cpi_next  = 6'd0;
                    st_next   = inwin ? B_COPY : B_CHK;
                end
            end
            B_COPY: begin
                issue = cpi_reg < cmd_reg.frame_len;
                if (issue) begin
                    cwv_next = 1'b1;
                    cwa_next = base_reg + AW'(cpi_reg);
                    cpi_next = cpi_reg + 6'd1;
                end else if (!cwv_reg) begin
                    slen_we = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    st_next = B_CHK;
                end
            end
            B_CHK: begin
                if (valid_reg[head_reg]) begin
                    flen_next = slen_reg[head_reg];
                    base_next = AW'(head_reg) * MAXA;
                    pos_next  = 6'd0;
                    iss_next  = 4'd0;
                    word_next = 64'd0;
                    wcnt_next = (slen_reg[head_reg] > 6'd8) ? 4'd8 : slen_reg[head_reg][3:0];
                    if (slen_reg[head_reg] == 6'd0) begin
                        retire = 1'b1;
                    end else begin
                        st_next = B_RD;
                    end
                end else begin
                    st_next = B_FIN;
                end
            end
            B_RD: begin
                issue = iss_reg < wcnt_reg;
                if (issue) begin
                    rv_next   = 1'b1;
                    lane_next = iss_reg[2:0];
                    iss_next  = iss_reg + 4'd1;
                end else if (!rv_reg) begin
                    st_next = B_EMIT;
                end
            end
            B_EMIT: begin
                res.kind       = KIND_DATA;
                res.data_word  = word_reg;
                res.word_bytes = wcnt_reg;
                if (emit_ok) begin
                    emit = 1'b1;
                    if (pos_new == flen_reg) begin
                        retire  = 1'b1;
                        st_next = B_CHK;
                    end else begin
                        pos_next  = pos_new;
                        iss_next  = 4'd0;
                        word_next = 64'd0;
                        // remaining count is measured from the new position
                        wcnt_next = ((flen_reg - pos_new) > 6'd8) ? 4'd8
                                                                  : 4'(flen_reg - pos_new);
                        st_next   = B_RD;
                    end
                end
            end
            B_FIN: begin
                if (out_ok) begin
                    pop     = 1'b1;
                    st_next = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase

        // advance the window past a delivered frame
        if (retire) begin
            valid_next[head_reg] = 1'b0;
            exp_next  = exp_reg + 16'd1;
            head_next = (head_reg == HLAST) ? '0 : head_reg + HW'(1);
        end

        pv_next = pv_reg; pend_next = pend_reg; mv_next = mv_reg; md_next = md_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        if (emit) begin
            // hold the newest result until it is known whether it ends the run
            if (pv_reg) begin
                md_next = pend_reg;
                mv_next = 1'b1;
            end
            pend_next = res;
            pv_next   = 1'b1;
        end else if (pop) begin
            md_next = pend_reg;
            md_next.run_last = 1'b1;
            mv_next = 1'b1;
            pv_next = 1'b0;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        slot_reg <= slot_next;
        base_reg <= base_next;
        cwa_reg  <= cwa_next;
        flen_reg <= flen_next;
        pos_reg  <= pos_next;
        wcnt_reg <= wcnt_next;
        iss_reg  <= iss_next;
        lane_reg <= lane_next;
        word_reg <= word_next;
        cpi_reg  <= cpi_next;
        pend_reg <= pend_next;
        md_reg   <= md_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= B_IDLE;
            exp_reg   <= 16'd0;
            head_reg  <= '0;
            valid_reg <= '0;
            cwv_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            exp_reg   <= exp_next;
            head_reg  <= head_next;
            valid_reg <= valid_next;
            cwv_reg   <= cwv_next;
            rv_reg    <= rv_next;
            pv_reg    <= pv_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

// ----- rtl/core/arq_reorder_receiver.sv -----
// ARQ reorder receiver, top level. Front end takes one byte item per cycle while the
// two-frame queue (two staging banks) has room; it stalls when two judged frames wait.
// Back end per frame: takes it from the queue into the ACK state, copies it into its slot
// when in the window, checks the window head after each delivered frame and reads and
// emits each word of the in-order run. The ACK is held until the next result or the end
// of the run. Reset (aresetn low, synchronous) clears control state only.
module arq_reorder_receiver #(
    parameter int MAX_FRAME_BYTES = 46,
    parameter int WINDOW_FRAMES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  arqrr_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output arqrr_pkg::out_t  m_data
);
    import arqrr_pkg::*;

    localparam int SW = $clog2(2 * MAX_FRAME_BYTES);

    logic          q_full, q_empty, push, pop, stg_we;
    cmd_t          push_cmd, q_head;
    logic [SW-1:0] stg_waddr;
    logic [7:0]    stg_wdata;

    arqrr_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES), .SW(SW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_full(q_full), .push(push), .push_cmd(push_cmd),
        .stg_we(stg_we), .stg_waddr(stg_waddr), .stg_wdata(stg_wdata)
    );

    arqrr_cmdq u_cmdq (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_cmd(push_cmd),
        .pop(pop), .head(q_head), .full(q_full), .empty(q_empty)
    );

    arqrr_back #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES), .WINDOW_FRAMES(WINDOW_FRAMES), .SW(SW)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .stg_we(stg_we), .stg_waddr(stg_waddr),
        .stg_wdata(stg_wdata), .q_empty(q_empty), .q_head(q_head), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ----- rtl/core/arqrr_checker.sv -----
// Port-level checks for the ARQ reorder receiver, bound to the top level.
// Depends on arqrr_pkg.
module arqrr_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input arqrr_pkg::out_t  m_data
);
    import arqrr_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_ACK |-> m_data.data_word == 64'd0
            && m_data.word_bytes == 4'd0)
        else $error("ack carries data");

    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_DATA |-> m_data.word_bytes != 4'd0
            && m_data.word_bytes <= 4'd8 && m_data.ack_seq == 16'd0)
        else $error("bad data word");

endmodule

bind arq_reorder_receiver arqrr_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ----- verif/arq_reorder_receiver_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for arq_reorder_receiver: frames of byte items in, ACKs
// and delivered words out, checked against an in-bench model of the window.
// Depends on arqrr_pkg and the arq_reorder_receiver RTL.
module arq_reorder_receiver_tb;
    import arqrr_pkg::*;

    localparam int MAXB = 46;
    localparam int WIN = 8;
    localparam int WDOG_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    arq_reorder_receiver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // model state
    logic [15:0] exp_seq;
    int unsigned head;
    bit win_valid [WIN];
    int unsigned win_len [WIN];
    logic [7:0] win_bytes [WIN][MAXB];
    logic [7:0] stage [MAXB];
    logic [15:0] run_sum;
    int unsigned nbytes;
    bit ovf;

    in_t item_q[$];
    out_t result_q[$];
    int errors = 0;
    int mismatches = 0;
    bit tail_phase = 0;
    bit hold_rx = 0;
    bit timed_out = 0;
    bit in_acc = 0;
    int idle_cycles = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic out_t mk_result(logic k, logic [15:0] a, logic [63:0] w,
                                       logic [3:0] nb);
        out_t r;
        r.kind = k;
        r.ack_seq = a;
        r.data_word = w;
        r.word_bytes = nb;
        r.run_last = 1'b0;
        return r;
    endfunction

    // Update the model for one accepted item and queue what it yields.
    task automatic predict_receive(in_t it);
        int unsigned off, sl, pos, cnt, first;
        logic [63:0] w;
        out_t r;
        if (it.frame_len != 0) begin
            run_sum = run_sum + it.data_byte;
            if (nbytes < MAXB) stage[nbytes] = it.data_byte;
            if (nbytes < 63) nbytes++;
            else ovf = 1;
        end
        if (!it.frame_last) return;
        if (it.frame_len > MAXB || nbytes != it.frame_len || ovf || run_sum != it.frame_sum) begin
            run_sum = 0; nbytes = 0; ovf = 0;
            return;
        end
        first = result_q.size();
        result_q.push_back(mk_result(KIND_ACK, it.seq_no, 64'd0, 4'd0));
        off = 16'(it.seq_no - exp_seq);
        if (off < WIN) begin
            sl = (head + off) % WIN;
            for (int b = 0; b < it.frame_len; b++) win_bytes[sl][b] = stage[b];
            win_len[sl] = it.frame_len;
            win_valid[sl] = 1;
        end
        run_sum = 0; nbytes = 0; ovf = 0;
        for (int f = 0; f < WIN && win_valid[head]; f++) begin
            pos = 0;
            while (pos < win_len[head]) begin
                cnt = win_len[head] - pos;
                if (cnt > 8) cnt = 8;
                w = '0;
                for (int b = 0; b < cnt; b++) w[8*b +: 8] = win_bytes[head][pos+b];
                result_q.push_back(mk_result(KIND_DATA, 16'd0, w, 4'(cnt)));
                pos += cnt;
            end
            win_valid[head] = 0;
            exp_seq = exp_seq + 16'd1;
            head = (head + 1) % WIN;
        end
        r = result_q[result_q.size()-1];
        r.run_last = 1'b1;
        result_q[result_q.size()-1] = r;
    endtask

    // Build one frame; corrupt selects a bad checksum, length or overrun.
    task automatic queue_frame(logic [15:0] seq, int len, int corrupt);
        in_t it;
        logic [15:0] s;
        int n;
        logic [7:0] b [64];
        s = 0;
        n = (corrupt == 2) ? len + 1 : len;
        if (corrupt == 3) n = 64 + $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            b[i % 64] = $urandom_range(0, 255);
            s = s + b[i % 64];
        end
        if (corrupt == 1) s = s ^ (16'd1 << $urandom_range(0, 15));
        if (len == 0 && n == 0) begin
            it.seq_no = seq; it.frame_len = 0; it.frame_sum = s;
            it.data_byte = $urandom_range(0, 255); it.frame_last = 1;
            item_q.push_back(it);
            return;
        end
        for (int i = 0; i < n; i++) begin
            it.seq_no = (i == n-1) ? seq : 16'($urandom);
            it.frame_len = (i == n-1 || $urandom_range(0, 1)) ? 6'(len) : 6'($urandom_range(1, 63));
            it.frame_sum = (i == n-1) ? s : 16'($urandom);
            it.data_byte = b[i % 64];
            it.frame_last = (i == n-1);
            item_q.push_back(it);
        end
    endtask

    task automatic wait_drain();
        while (item_q.size() != 0 || s_valid || result_q.size() != 0) @(posedge aclk);
    endtask

    // driver
    int tx_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (s_valid && !in_acc) begin
            // hold
        end else begin
            if (in_acc) item_q.pop_front();
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 0;
            end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(0, 10);
                s_valid <= 0;
            end else if (item_q.size() != 0) begin
                s_valid <= 1;
                s_data <= item_q[0];
            end else begin
                s_valid <= 0;
            end
        end
    end

    // receiver side
    int rx_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn || hold_rx) begin
            m_ready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 0;
        end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 10);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        out_t want;
        in_acc = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (in_acc) predict_receive(s_data);
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result %p", m_data);
                end else begin
                    want = result_q.pop_front();
                    if (m_data.kind != want.kind || m_data.ack_seq != want.ack_seq ||
                        m_data.data_word != want.data_word ||
                        m_data.word_bytes != want.word_bytes ||
                        m_data.run_last != want.run_last) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: expected %p actual %p", want, m_data);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else if (!hold_rx) idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) timed_out = 1;
        end
    end

    always @(posedge aclk) begin
        if (timed_out) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [15:0] sq;
        int lens [6] = '{0, 1, 8, 9, 45, 46};
        s_valid = 0; m_ready = 0; s_data = '0; aresetn = 0;
        exp_seq = 0; head = 0; run_sum = 0; nbytes = 0; ovf = 0;
        foreach (win_valid[i]) begin win_valid[i] = 0; win_len[i] = 0; end
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // directed: lengths at the edges, out-of-order, duplicate, stale, bad frames
        queue_frame(16'd0, 0, 0);
        queue_frame(16'd2, 46, 0);
        queue_frame(16'd2, 9, 0);
        queue_frame(16'd1, 8, 0);
        queue_frame(16'd11, 5, 0);
        queue_frame(16'hFFFF, 3, 0);
        queue_frame(16'd3, 47, 0);
        queue_frame(16'd3, 4, 1);
        queue_frame(16'd3, 4, 2);
        queue_frame(16'd3, 63, 3);
        queue_frame(16'd3, 1, 0);
        wait_drain();

        // long receiver stall while the sender keeps offering
        for (int i = 0; i < 3; i++) queue_frame(16'(4 + i), 12, 0);
        hold_rx = 1;
        repeat (200) @(posedge aclk);
        hold_rx = 0;
        wait_drain();

        // random: mostly good frames around the window, some noise
        for (int f = 0; f < 6; f++) begin
            case ($urandom_range(0, 9))
                0: sq = 16'($urandom);
                1: sq = exp_seq - 16'($urandom_range(1, 4));
                default: sq = exp_seq + 16'($urandom_range(0, WIN + 1));
            endcase
            queue_frame(sq, (f % 7 == 0) ? lens[$urandom_range(0, 5)] : $urandom_range(0, 12),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
        end
        for (int f = 0; f < 4; f++) queue_frame(exp_seq + 16'(f), $urandom_range(0, 12), 0);
        wait_drain();
        tail_phase = 1;
        for (int f = 0; f < 3; f++) queue_frame(exp_seq + 16'(f), $urandom_range(0, 20), 0);
        wait_drain();
        repeat (200) @(posedge aclk);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/arqrr_pkg.sv
rtl/core/arqrr_front.sv
rtl/core/arqrr_cmdq.sv
rtl/core/arqrr_back.sv
rtl/core/arq_reorder_receiver.sv
rtl/core/arqrr_checker.sv
verif/arq_reorder_receiver_tb.sv
